FILE: hw/rtl/lidar_polar_to_vehicle_xy_assert.svh
// assertion macros shared by lpv_fifo and lpv_back
`ifndef LIDAR_POLAR_TO_VEHICLE_XY_ASSERT_SVH
`define LIDAR_POLAR_TO_VEHICLE_XY_ASSERT_SVH
// property that must hold in the cycle after the trigger
`define LPV_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("assertion failed");
// property that must hold in the same cycle
`define LPV_ASSERT_NOW(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/lpv_pkg.sv
// ---------------------------------------------------------------------------
// lpv_pkg
// shared types and constants of the polar to vehicle-frame converter
// ---------------------------------------------------------------------------
package lpv_pkg;
    localparam int CordicSteps = 24;
    localparam int AngW = 33;
    localparam logic [31:0] PhaseK = 32'd683565276;
    localparam logic signed [31:0] HalfPiQ30 = 32'sd1686629713;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic [23:0] FarMm = 24'd10000000;

    typedef enum logic [1:0] {
        KIND_MEASURED = 2'd0,
        KIND_FAR      = 2'd1,
        KIND_CLOSE    = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_START = 3'd0, REG_STEP = 3'd1, REG_VSTART = 3'd2, REG_VEND = 3'd3,
        REG_MINR = 3'd4, REG_MAXR = 3'd5, REG_MX = 3'd6, REG_MY = 3'd7
    } reg_idx_t;

    // front part output word
    typedef struct packed {
        logic signed [AngW-1:0] ang;
        logic [23:0]            r;
        kind_t                  kind;
        logic                   last;
    } fwd_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] t;
        case (i)
            0: t = 34'sd843314856;  1: t = 34'sd497837829;
            2: t = 34'sd263043836;  3: t = 34'sd133525158;
            4: t = 34'sd67021686;   5: t = 34'sd33543515;
            6: t = 34'sd16775850;   7: t = 34'sd8388437;
            8: t = 34'sd4194282;    9: t = 34'sd2097149;
            10: t = 34'sd1048575;   11: t = 34'sd524287;
            12: t = 34'sd262143;    13: t = 34'sd131071;
            14: t = 34'sd65535;     15: t = 34'sd32767;
            16: t = 34'sd16383;     17: t = 34'sd8191;
            18: t = 34'sd4095;      19: t = 34'sd2047;
            20: t = 34'sd1023;      21: t = 34'sd511;
            22: t = 34'sd255;       23: t = 34'sd127;
            default: t = '0;
        endcase
        return t;
    endfunction
endpackage

FILE: hw/rtl/lpv_fifo.sv
// ---------------------------------------------------------------------------
// lpv_fifo
// small register queue used between the front and back parts and at the output
// ---------------------------------------------------------------------------
`include "lidar_polar_to_vehicle_xy_assert.svh"
module lpv_fifo #(
    parameter int W = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [W-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic do_push, do_pop;

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else begin
            if (do_push) begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop) begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    `LPV_ASSERT_NOW(a_no_overflow, full, cnt_reg == (AW+1)'(DEPTH))
    `LPV_ASSERT_NEXT(a_push_counts, do_push && !do_pop, cnt_reg != '0)
    `LPV_ASSERT_NEXT(a_pop_drains, do_pop && !do_push && cnt_reg == 1, empty)
endmodule

FILE: hw/rtl/lpv_front.sv
// ---------------------------------------------------------------------------
// lpv_front
// computes the beam angle and classifies each point, one per cycle unless out_ready stalls it
// ---------------------------------------------------------------------------
module lpv_front #(
    parameter int MAX_BEAMS = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         distance_mm,
    input  logic [11:0]         beam_index,
    input  logic                last_in_scan,
    input  logic signed [19:0]  scan_start_angle,
    input  logic signed [15:0]  angle_step,
    input  logic signed [19:0]  view_start,
    input  logic signed [19:0]  view_end,
    input  logic [15:0]         min_range_mm,
    input  logic [15:0]         max_range_mm,
    output logic                out_valid,
    input  logic                out_ready,
    output lpv_pkg::fwd_t       out_word
);
    // stage 1: angle, stage 2: classify
    logic               s1_v_reg;
    logic signed [lpv_pkg::AngW-1:0] s1_ang_reg;
    logic [15:0]        s1_d_reg;
    logic               s1_big_reg, s1_last_reg;
    logic               s2_v_reg;
    lpv_pkg::fwd_t      s2_reg, s2_next;
    logic               adv2, adv1;
    logic               in_view;

    assign adv2 = !s2_v_reg || out_ready;
    assign adv1 = !s1_v_reg || adv2;
    assign in_ready = adv1;
    assign out_valid = s2_v_reg;
    assign out_word = s2_reg;

    always_comb begin
        in_view = !s1_big_reg
            && s1_ang_reg >= lpv_pkg::AngW'(view_start)
            && s1_ang_reg <= lpv_pkg::AngW'(view_end);
        s2_next.ang = s1_ang_reg;
        s2_next.last = s1_last_reg;
        s2_next.r = {8'd0, s1_d_reg};
        s2_next.kind = lpv_pkg::KIND_MEASURED;
        if (!in_view || s1_d_reg == '0) begin
            s2_next.r = lpv_pkg::FarMm;
            s2_next.kind = lpv_pkg::KIND_FAR;
        end
        else if (s1_d_reg < min_range_mm) begin
            s2_next.kind = lpv_pkg::KIND_CLOSE;
        end
        else if (s1_d_reg > max_range_mm) begin
            s2_next.r = lpv_pkg::FarMm;
            s2_next.kind = lpv_pkg::KIND_FAR;
        end
    end

    always_ff @(posedge clk) begin
        if (adv1 && in_valid) begin
            s1_ang_reg <= lpv_pkg::AngW'(scan_start_angle)
                + lpv_pkg::AngW'($signed({1'b0, beam_index})) * lpv_pkg::AngW'(angle_step);
            s1_d_reg <= distance_mm;
            s1_big_reg <= (32'(beam_index) >= 32'(MAX_BEAMS));
            s1_last_reg <= last_in_scan;
        end
        if (adv2 && s1_v_reg) begin
            s2_reg <= s2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else begin
            if (adv1) begin
                s1_v_reg <= in_valid;
            end
            if (adv2) begin
                s2_v_reg <= s1_v_reg;
            end
        end
    end
endmodule

FILE: hw/rtl/lpv_back.sv
// ---------------------------------------------------------------------------
// lpv_back
// pipelined cordic and position scaling, stalls as one unit
// ---------------------------------------------------------------------------
`include "lidar_polar_to_vehicle_xy_assert.svh"
module lpv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lpv_pkg::fwd_t      in_word,
    input  logic signed [15:0] mount_x_mm,
    input  logic signed [15:0] mount_y_mm,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [24:0]        pos_x_mm,
    output logic [24:0]        pos_y_mm,
    output logic [20:0]        heading,
    output logic [1:0]         point_kind,
    output logic               last_out
);
    localparam int N = lpv_pkg::CordicSteps;
    localparam int S = N + 5;

    logic en;
    logic [S-1:0] v_reg;
    assign en = !v_reg[S-1] || out_ready;
    assign in_ready = en;
    assign out_valid = v_reg[S-1];

    // stage a: phase product
    logic [63:0] ph_prod;
    logic [31:0] ph_reg;
    lpv_pkg::fwd_t wa_reg;
    assign ph_prod = 64'($signed(in_word.ang)) * 64'(lpv_pkg::PhaseK);

    // stage b: quadrant and residual
    logic [1:0] q;
    logic [31:0] dres;
    logic signed [63:0] zprod;
    logic signed [63:0] zp_reg;
    logic [1:0] qb_reg;
    lpv_pkg::fwd_t wb_reg;
    assign q = 2'((ph_reg + 32'h2000_0000) >> 30);
    assign dres = ph_reg - {q, 30'd0};
    assign zprod = 64'($signed(dres)) * 64'(lpv_pkg::HalfPiQ30);

    // cordic chain
    logic signed [33:0] cx_reg [N+1];
    logic signed [33:0] cy_reg [N+1];
    logic signed [33:0] cz_reg [N+1];
    logic [1:0] cq_reg [N+1];
    lpv_pkg::fwd_t cw_reg [N+1];

    always_ff @(posedge clk) begin
        if (en) begin
            ph_reg <= ph_prod[47:16];
            wa_reg <= in_word;
            zp_reg <= zprod + 64'sd536870912;
            qb_reg <= q;
            wb_reg <= wa_reg;
            cx_reg[0] <= lpv_pkg::CordicGain;
            cy_reg[0] <= '0;
            cz_reg[0] <= 34'(zp_reg >>> 30);
            cq_reg[0] <= qb_reg;
            cw_reg[0] <= wb_reg;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cordic
        always_ff @(posedge clk) begin
            if (en) begin
                if (!cz_reg[i][33]) begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - lpv_pkg::atan_q30(i);
                end
                else begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + lpv_pkg::atan_q30(i);
                end
                cq_reg[i+1] <= cq_reg[i];
                cw_reg[i+1] <= cw_reg[i];
            end
        end
    end

    // quadrant rotate, multiply, then offset and saturate
    logic signed [33:0] c_t, s_t;
    always_comb begin
        case (cq_reg[N])
            2'd0: begin c_t = cx_reg[N]; s_t = cy_reg[N]; end
            2'd1: begin c_t = -cy_reg[N]; s_t = cx_reg[N]; end
            2'd2: begin c_t = -cx_reg[N]; s_t = -cy_reg[N]; end
            default: begin c_t = cy_reg[N]; s_t = -cx_reg[N]; end
        endcase
    end

    logic signed [58:0] mx_reg, my_reg;
    lpv_pkg::fwd_t wm_reg;
    logic signed [58:0] sx, sy;
    logic signed [29:0] tx, ty;
    assign sx = (mx_reg + 59'sd536870912) >>> 30;
    assign sy = (my_reg + 59'sd536870912) >>> 30;
    assign tx = 30'(sx) + 30'(mount_x_mm);
    assign ty = 30'(sy) + 30'(mount_y_mm);

    function automatic logic [24:0] sat25(input logic signed [29:0] v);
        if (v > 30'sd16777215) return 25'h0FF_FFFF;
        if (v < -30'sd16777216) return 25'h100_0000;
        return v[24:0];
    endfunction

    logic [24:0] ox_reg, oy_reg;
    logic [20:0] oh_reg;
    logic [1:0] ok_reg;
    logic ol_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            mx_reg <= $signed({1'b0, cw_reg[N].r}) * c_t;
            my_reg <= $signed({1'b0, cw_reg[N].r}) * s_t;
            wm_reg <= cw_reg[N];
            ok_reg <= wm_reg.kind;
            ol_reg <= wm_reg.last;
            if (wm_reg.kind == lpv_pkg::KIND_CLOSE) begin
                ox_reg <= '0;
                oy_reg <= '0;
                oh_reg <= '0;
            end
            else begin
                ox_reg <= sat25(tx);
                oy_reg <= sat25(ty);
                if (wm_reg.ang > 33'sd1048575) oh_reg <= 21'h0F_FFFF;
                else if (wm_reg.ang < -33'sd1048576) oh_reg <= 21'h10_0000;
                else oh_reg <= wm_reg.ang[20:0];
            end
        end
    end

    assign pos_x_mm = ox_reg;
    assign pos_y_mm = oy_reg;
    assign heading = oh_reg;
    assign point_kind = ok_reg;
    assign last_out = ol_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[S-2:0], in_valid};
        end
    end

    `LPV_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(pos_x_mm))
    `LPV_ASSERT_NOW(a_close_zero, out_valid && point_kind == lpv_pkg::KIND_CLOSE, pos_x_mm == '0 && heading == '0)
endmodule

FILE: hw/rtl/lidar_polar_to_vehicle_xy.sv
// ---------------------------------------------------------------------------
// lidar_polar_to_vehicle_xy
// range point to vehicle-frame x, y and heading converter
// ---------------------------------------------------------------------------
// usage: push a word (distance_mm, beam_index, last_in_scan) while full is low;
// results come out in order, one per input, while empty is low; pop takes one.
// the front part forms the beam angle and classifies the point,
// a 4 entry queue feeds the back part: phase multiply, quadrant split,
// a 24 stage pipelined cordic, one multiply stage and one output stage.
// throughput is one word per cycle when pop does not stall the pipe, set by the one-step-per-stage cordic.
// when pop stays low the output queue fills, then the cordic pipe freezes,
// then the middle queue fills and full rises; no word is lost.
// reset empties all queues and loads the register defaults (full view window,
// max range 65535). registers sit at byte address 4*index on the apb port; the
// user writes them only while no word is in flight; the block does not check.
// ---------------------------------------------------------------------------
module lidar_polar_to_vehicle_xy #(
    parameter int MAX_BEAMS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [15:0] distance_mm,
    input  logic [11:0] beam_index,
    input  logic        last_in_scan,
    output logic        empty,
    input  logic        pop,
    output logic [24:0] pos_x_mm,
    output logic [24:0] pos_y_mm,
    output logic [20:0] heading,
    output logic [1:0]  point_kind,
    output logic        last_out
);
    logic [19:0] start_reg, vstart_reg, vend_reg;
    logic [15:0] step_reg, minr_reg, maxr_reg, mx_reg, my_reg;
    lpv_pkg::reg_idx_t ridx;
    assign ridx = lpv_pkg::reg_idx_t'(paddr[4:2]);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_reg <= '0;
            step_reg <= '0;
            vstart_reg <= 20'h80000;
            vend_reg <= 20'h7FFFF;
            minr_reg <= '0;
            maxr_reg <= 16'hFFFF;
            mx_reg <= '0;
            my_reg <= '0;
        end
        else if (psel && penable && pwrite) begin
            unique case (ridx)
                lpv_pkg::REG_START:  start_reg <= pwdata[19:0];
                lpv_pkg::REG_STEP:   step_reg <= pwdata[15:0];
                lpv_pkg::REG_VSTART: vstart_reg <= pwdata[19:0];
                lpv_pkg::REG_VEND:   vend_reg <= pwdata[19:0];
                lpv_pkg::REG_MINR:   minr_reg <= pwdata[15:0];
                lpv_pkg::REG_MAXR:   maxr_reg <= pwdata[15:0];
                lpv_pkg::REG_MX:     mx_reg <= pwdata[15:0];
                default:             my_reg <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            lpv_pkg::REG_START:  prdata = {12'd0, start_reg};
            lpv_pkg::REG_STEP:   prdata = {16'd0, step_reg};
            lpv_pkg::REG_VSTART: prdata = {12'd0, vstart_reg};
            lpv_pkg::REG_VEND:   prdata = {12'd0, vend_reg};
            lpv_pkg::REG_MINR:   prdata = {16'd0, minr_reg};
            lpv_pkg::REG_MAXR:   prdata = {16'd0, maxr_reg};
            lpv_pkg::REG_MX:     prdata = {16'd0, mx_reg};
            default:             prdata = {16'd0, my_reg};
        endcase
    end

    logic f_rdy, f_v, q_full, q_empty, b_rdy, b_v, o_full;
    lpv_pkg::fwd_t f_word, q_word;
    assign full = !f_rdy;

    lpv_front #(.MAX_BEAMS(MAX_BEAMS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(push), .in_ready(f_rdy),
        .distance_mm(distance_mm), .beam_index(beam_index),
        .last_in_scan(last_in_scan),
        .scan_start_angle(start_reg), .angle_step(step_reg),
        .view_start(vstart_reg), .view_end(vend_reg),
        .min_range_mm(minr_reg), .max_range_mm(maxr_reg),
        .out_valid(f_v), .out_ready(!q_full), .out_word(f_word)
    );

    lpv_fifo #(.W($bits(lpv_pkg::fwd_t)), .DEPTH(4)) u_mid (
        .clk(clk), .rst_n(rst_n),
        .push(f_v), .wdata(f_word), .full(q_full),
        .pop(b_rdy), .rdata(q_word), .empty(q_empty)
    );

    logic [24:0] bx, by;
    logic [20:0] bh;
    logic [1:0] bk;
    logic bl;

    lpv_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(!q_empty), .in_ready(b_rdy), .in_word(q_word),
        .mount_x_mm(mx_reg), .mount_y_mm(my_reg),
        .out_valid(b_v), .out_ready(!o_full),
        .pos_x_mm(bx), .pos_y_mm(by), .heading(bh),
        .point_kind(bk), .last_out(bl)
    );

    lpv_fifo #(.W(74), .DEPTH(2)) u_out (
        .clk(clk), .rst_n(rst_n),
        .push(b_v), .wdata({bx, by, bh, bk, bl}), .full(o_full),
        .pop(pop), .rdata({pos_x_mm, pos_y_mm, heading, point_kind, last_out}),
        .empty(empty)
    );
endmodule
